@@ rtl/core/interval_overlap_best_match_defines.svh @@
// assertion macros for the interval overlap best match block
// used by the top level, no other dependencies
`ifndef INTERVAL_OVERLAP_BEST_MATCH_DEFINES_SVH
`define INTERVAL_OVERLAP_BEST_MATCH_DEFINES_SVH
`ifndef SYNTHESIS
`define IOBM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define IOBM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define IOBM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define IOBM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/core/iobm_pkg.sv @@
// shared types, codes and helper functions of the interval overlap best match block
// no dependencies
`default_nettype none

package iobm_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int ID_WIDTH_DEF    = 24;
    localparam int TOTAL_WIDTH     = 32;
    localparam int PRI_WIDTH       = 16;
    localparam int KIND_WIDTH      = 3;
    localparam int N_KINDS         = 5;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [1:0] CMD_START  = 2'd0;
    localparam logic [1:0] CMD_SEG    = 2'd1;
    localparam logic [1:0] CMD_FINISH = 2'd2;

    localparam logic [1:0] MODE_INCLUDE_FIRST = 2'd0;
    localparam logic [1:0] MODE_INCLUDE_ONLY  = 2'd1;
    localparam logic [1:0] MODE_EQUAL         = 2'd2;

    localparam logic [KIND_WIDTH-1:0] KIND_EXON = 3'd0;

    typedef logic [TOTAL_WIDTH-1:0] t_total;

    typedef enum logic [1:0] {
        CLS_NONE    = 2'd0,
        CLS_PARTIAL = 2'd1,
        CLS_INCLUDE = 2'd2
    } t_class;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_SEG    = 2'd1,
        OP_FINISH = 2'd2
    } t_op;

    typedef struct packed {
        t_op                         op;
        logic [KIND_WIDTH-1:0]       kind;
        logic                        last;
        t_class                      cls;
        t_total                      overlap;
        logic signed [PRI_WIDTH-1:0] pri;
    } t_q_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic signed [2:0] class_score(input logic [1:0] mode,
                                                      input t_class cls);
        logic signed [2:0] s;
        s = 3'sd0;
        case (cls)
            CLS_PARTIAL: begin
                case (mode)
                    MODE_INCLUDE_ONLY: s = -3'sd1;
                    default:           s = 3'sd1;
                endcase
            end
            CLS_INCLUDE: begin
                case (mode)
                    MODE_EQUAL: s = 3'sd1;
                    default:    s = 3'sd2;
                endcase
            end
            default: s = 3'sd0;
        endcase
        return s;
    endfunction

    function automatic t_total sat_add(input t_total a, input t_total b);
        logic [TOTAL_WIDTH:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TOTAL_WIDTH] ? {TOTAL_WIDTH{1'b1}} : s[TOTAL_WIDTH-1:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/iobm_if.sv @@
// channel interfaces: input items, result items and configuration writes
// depends on iobm_pkg for default widths
`default_nettype none

interface iobm_in_if #(
    parameter int COORD_WIDTH = iobm_pkg::COORD_WIDTH_DEF,
    parameter int ID_WIDTH    = iobm_pkg::ID_WIDTH_DEF
);
    logic                                  valid;
    logic                                  ready;
    logic [1:0]                            cmd;
    logic [COORD_WIDTH-1:0]                query_start;
    logic [COORD_WIDTH-1:0]                query_end;
    logic [COORD_WIDTH-1:0]                seg_start;
    logic [COORD_WIDTH-1:0]                seg_end;
    logic [iobm_pkg::KIND_WIDTH-1:0]       seg_kind;
    logic [COORD_WIDTH-1:0]                tx_start;
    logic [COORD_WIDTH-1:0]                tx_end;
    logic signed [iobm_pkg::PRI_WIDTH-1:0] tx_priority;
    logic [ID_WIDTH-1:0]                   tx_id;
    logic                                  last_of_transcript;

    modport source (
        output valid, cmd, query_start, query_end, seg_start, seg_end, seg_kind,
               tx_start, tx_end, tx_priority, tx_id, last_of_transcript,
        input  ready
    );
    modport sink (
        input  valid, cmd, query_start, query_end, seg_start, seg_end, seg_kind,
               tx_start, tx_end, tx_priority, tx_id, last_of_transcript,
        output ready
    );
endinterface

interface iobm_out_if #(
    parameter int ID_WIDTH = iobm_pkg::ID_WIDTH_DEF
);
    logic                                  valid;
    logic                                  ready;
    logic                                  found;
    logic [1:0]                            match_type;
    logic [ID_WIDTH-1:0]                   winner_id;
    logic signed [iobm_pkg::PRI_WIDTH-1:0] winner_priority;
    logic [iobm_pkg::TOTAL_WIDTH-1:0]      exon_overlap;
    logic [iobm_pkg::TOTAL_WIDTH-1:0]      intron_overlap;
    logic [iobm_pkg::TOTAL_WIDTH-1:0]      cds_overlap;
    logic [iobm_pkg::TOTAL_WIDTH-1:0]      utr5_overlap;
    logic [iobm_pkg::TOTAL_WIDTH-1:0]      utr3_overlap;

    modport source (
        output valid, found, match_type, winner_id, winner_priority, exon_overlap,
               intron_overlap, cds_overlap, utr5_overlap, utr3_overlap,
        input  ready
    );
    modport sink (
        input  valid, found, match_type, winner_id, winner_priority, exon_overlap,
               intron_overlap, cds_overlap, utr5_overlap, utr3_overlap,
        output ready
    );
endinterface

interface iobm_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/iobm_front.sv @@
// front end: accepts items, holds the query bounds, clips segment overlap and classes candidates
// depends on iobm_pkg and iobm_in_if
`default_nettype none

module iobm_front #(
    parameter int COORD_WIDTH = iobm_pkg::COORD_WIDTH_DEF,
    parameter int ID_WIDTH    = iobm_pkg::ID_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    iobm_in_if.sink                   i_in,
    input  wire iobm_pkg::t_q_status  i_q_status,
    output logic                      o_push,
    output iobm_pkg::t_q_item         o_item,
    output logic [ID_WIDTH-1:0]       o_id
);

    localparam int TW = iobm_pkg::TOTAL_WIDTH;

    logic [COORD_WIDTH-1:0] r_qs, r_qe;
    logic [COORD_WIDTH-1:0] n_qs, n_qe;
    logic [COORD_WIDTH-1:0] lo, hi, ov_full;
    logic [TW-1:0]          ov_sat;
    logic                   accept;
    logic                   cmd_ok;
    iobm_pkg::t_op          op;

    assign i_in.ready = !i_q_status.full;
    assign accept     = i_in.valid && i_in.ready;

    assign lo      = (i_in.seg_start > r_qs) ? i_in.seg_start : r_qs;
    assign hi      = (i_in.seg_end < r_qe) ? i_in.seg_end : r_qe;
    assign ov_full = (hi > lo) ? (hi - lo) : '0;

    generate
        if (COORD_WIDTH > TW) begin : g_clip
            assign ov_sat = (|ov_full[COORD_WIDTH-1:TW]) ? {TW{1'b1}} : ov_full[TW-1:0];
        end else begin : g_ext
            assign ov_sat = TW'(ov_full);
        end
    endgenerate

    always_comb begin
        cmd_ok = 1'b1;
        unique case (i_in.cmd)
            iobm_pkg::CMD_START:  op = iobm_pkg::OP_START;
            iobm_pkg::CMD_SEG:    op = iobm_pkg::OP_SEG;
            iobm_pkg::CMD_FINISH: op = iobm_pkg::OP_FINISH;
            default: begin
                op     = iobm_pkg::OP_START;
                cmd_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_qs = r_qs;
        n_qe = r_qe;
        if (accept && i_in.cmd == iobm_pkg::CMD_START) begin
            n_qs = i_in.query_start;
            n_qe = i_in.query_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qs <= '0;
            r_qe <= '0;
        end else begin
            r_qs <= n_qs;
            r_qe <= n_qe;
        end
    end

    assign o_push         = accept && cmd_ok;
    assign o_item.op      = op;
    assign o_item.kind    = i_in.seg_kind;
    assign o_item.last    = i_in.last_of_transcript;
    assign o_item.cls     = (i_in.tx_start <= r_qs && i_in.tx_end >= r_qe) ?
                            iobm_pkg::CLS_INCLUDE : iobm_pkg::CLS_PARTIAL;
    assign o_item.overlap = ov_sat;
    assign o_item.pri     = i_in.tx_priority;
    assign o_id           = i_in.tx_id;

endmodule

`default_nettype wire

@@ rtl/core/iobm_queue.sv @@
// short item queue between the front and back ends
// depends on iobm_pkg
`default_nettype none

module iobm_queue #(
    parameter int ID_WIDTH = iobm_pkg::ID_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire iobm_pkg::t_q_item    i_item,
    input  wire logic [ID_WIDTH-1:0]  i_id,
    input  wire logic                 i_pop,
    output iobm_pkg::t_q_item         o_head,
    output logic [ID_WIDTH-1:0]       o_head_id,
    output iobm_pkg::t_q_status       o_status
);

    localparam int DEPTH = iobm_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    iobm_pkg::t_q_item   r_item [DEPTH];
    logic [ID_WIDTH-1:0] r_id   [DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr, r_rd_ptr, n_wr_ptr, n_rd_ptr;
    logic [CNT_W-1:0]    r_cnt, n_cnt;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_item[r_wr_ptr] <= i_item;
            r_id[r_wr_ptr]   <= i_id;
        end
    end

    assign o_head         = r_item[r_rd_ptr];
    assign o_head_id      = r_id[r_rd_ptr];
    assign o_status.full  = (r_cnt == CNT_W'(DEPTH));
    assign o_status.empty = (r_cnt == '0);

endmodule

`default_nettype wire

@@ rtl/core/iobm_back.sv @@
// back end: per-kind running totals, candidate ranking, best record and result register
// depends on iobm_pkg, iobm_out_if and iobm_cfg_if
`default_nettype none

module iobm_back #(
    parameter int ID_WIDTH = iobm_pkg::ID_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    iobm_cfg_if.sink                  i_cfg,
    input  wire iobm_pkg::t_q_item    i_head,
    input  wire logic [ID_WIDTH-1:0]  i_head_id,
    input  wire iobm_pkg::t_q_status  i_q_status,
    output logic                      o_pop,
    iobm_out_if.source                o_out
);

    localparam int NK = iobm_pkg::N_KINDS;
    localparam int PW = iobm_pkg::PRI_WIDTH;

    logic [1:0]             r_mode;
    iobm_pkg::t_total       r_run      [NK];
    iobm_pkg::t_total       r_best_tot [NK];
    iobm_pkg::t_class       r_best_cls;
    logic signed [PW-1:0]   r_best_pri;
    logic [ID_WIDTH-1:0]    r_best_id;
    logic                   r_have;

    iobm_pkg::t_total       n_run      [NK];
    iobm_pkg::t_total       n_best_tot [NK];
    iobm_pkg::t_class       n_best_cls;
    logic signed [PW-1:0]   n_best_pri;
    logic [ID_WIDTH-1:0]    n_best_id;
    logic                   n_have;

    logic                   r_out_valid, n_out_valid;
    logic                   r_out_found;
    iobm_pkg::t_class       r_out_cls;
    logic signed [PW-1:0]   r_out_pri;
    logic [ID_WIDTH-1:0]    r_out_id;
    iobm_pkg::t_total       r_out_tot [NK];

    iobm_pkg::t_total       cand [NK];
    logic [NK-1:0]          tot_gt, tot_ne;
    logic                   tot_win;
    logic signed [2:0]      score_a, score_b;
    logic                   cand_exon, best_exon;
    logic                   beats;
    logic                   emit;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= iobm_pkg::MODE_INCLUDE_FIRST;
        end else if (i_cfg.valid) begin
            r_mode <= i_cfg.data;
        end
    end

    assign emit  = i_head.op == iobm_pkg::OP_FINISH;
    assign o_pop = !i_q_status.empty && (!emit || !r_out_valid || o_out.ready);

    always_comb begin
        for (int k = 0; k < NK; k++) begin
            cand[k]   = (i_head.kind == iobm_pkg::KIND_WIDTH'(k)) ?
                        iobm_pkg::sat_add(r_run[k], i_head.overlap) : r_run[k];
            tot_gt[k] = cand[k] > r_best_tot[k];
            tot_ne[k] = cand[k] != r_best_tot[k];
        end
        tot_win = 1'b0;
        for (int k = NK - 1; k >= 0; k--) begin
            if (tot_ne[k]) begin
                tot_win = tot_gt[k];
            end
        end
        score_a   = iobm_pkg::class_score(r_mode, i_head.cls);
        score_b   = iobm_pkg::class_score(r_mode, r_best_cls);
        cand_exon = cand[iobm_pkg::KIND_EXON] != '0;
        best_exon = r_best_tot[iobm_pkg::KIND_EXON] != '0;
        if (score_a != score_b) begin
            beats = score_a > score_b;
        end else if (cand_exon != best_exon) begin
            beats = cand_exon;
        end else if (i_head.pri != r_best_pri) begin
            beats = i_head.pri > r_best_pri;
        end else begin
            beats = tot_win;
        end
    end

    always_comb begin
        n_run      = r_run;
        n_best_tot = r_best_tot;
        n_best_cls = r_best_cls;
        n_best_pri = r_best_pri;
        n_best_id  = r_best_id;
        n_have     = r_have;
        if (o_pop) begin
            case (i_head.op)
                iobm_pkg::OP_START: begin
                    for (int k = 0; k < NK; k++) begin
                        n_run[k]      = '0;
                        n_best_tot[k] = '0;
                    end
                    n_best_cls = iobm_pkg::CLS_NONE;
                    n_best_pri = '0;
                    n_best_id  = '0;
                    n_have     = 1'b0;
                end
                iobm_pkg::OP_SEG: begin
                    n_run = cand;
                    if (i_head.last) begin
                        if (i_head.pri != '0 && beats) begin
                            n_best_tot = cand;
                            n_best_cls = i_head.cls;
                            n_best_pri = i_head.pri;
                            n_best_id  = i_head_id;
                            n_have     = 1'b1;
                        end
                        for (int k = 0; k < NK; k++) begin
                            n_run[k] = '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NK; k++) begin
                r_run[k]      <= '0;
                r_best_tot[k] <= '0;
            end
            r_best_cls <= iobm_pkg::CLS_NONE;
            r_best_pri <= '0;
            r_best_id  <= '0;
            r_have     <= 1'b0;
        end else begin
            r_run      <= n_run;
            r_best_tot <= n_best_tot;
            r_best_cls <= n_best_cls;
            r_best_pri <= n_best_pri;
            r_best_id  <= n_best_id;
            r_have     <= n_have;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_pop && emit) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_out_found <= r_have;
            r_out_cls   <= r_best_cls;
            r_out_pri   <= r_best_pri;
            r_out_id    <= r_best_id;
            r_out_tot   <= r_best_tot;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.found           = r_out_found;
    assign o_out.match_type      = r_out_cls;
    assign o_out.winner_id       = r_out_id;
    assign o_out.winner_priority = r_out_pri;
    assign o_out.exon_overlap    = r_out_tot[0];
    assign o_out.intron_overlap  = r_out_tot[1];
    assign o_out.cds_overlap     = r_out_tot[2];
    assign o_out.utr5_overlap    = r_out_tot[3];
    assign o_out.utr3_overlap    = r_out_tot[4];

endmodule

`default_nettype wire

@@ rtl/core/interval_overlap_best_match.sv @@
// top level: front end, item queue and back end of the interval overlap best match block
// path: an accepted finish item is queued, then popped into the result register once that is free
// throughput: one item per cycle unless a finish waits on an untaken result, set by the
// combinational saturating add and compare; the two-entry queue fills while a result waits
// reset: synchronous active low, pointers, totals, best record, r_mode and result valid clear at once
`default_nettype none
`include "interval_overlap_best_match_defines.svh"

module interval_overlap_best_match #(
    parameter int COORD_WIDTH = iobm_pkg::COORD_WIDTH_DEF,
    parameter int ID_WIDTH    = iobm_pkg::ID_WIDTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    iobm_cfg_if.sink   i_cfg,
    iobm_in_if.sink    i_in,
    iobm_out_if.source o_out
);

    logic                q_push, q_pop;
    iobm_pkg::t_q_item   q_item, q_head;
    logic [ID_WIDTH-1:0] q_id, q_head_id;
    iobm_pkg::t_q_status q_status;

    iobm_front #(
        .COORD_WIDTH(COORD_WIDTH),
        .ID_WIDTH   (ID_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_q_status(q_status),
        .o_push    (q_push),
        .o_item    (q_item),
        .o_id      (q_id)
    );

    iobm_queue #(
        .ID_WIDTH(ID_WIDTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_item   (q_item),
        .i_id     (q_id),
        .i_pop    (q_pop),
        .o_head   (q_head),
        .o_head_id(q_head_id),
        .o_status (q_status)
    );

    iobm_back #(
        .ID_WIDTH(ID_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (i_cfg),
        .i_head    (q_head),
        .i_head_id (q_head_id),
        .i_q_status(q_status),
        .o_pop     (q_pop),
        .o_out     (o_out)
    );

    `IOBM_ASSERT_NXT(a_finish_emits, i_clk, i_rst_n, q_pop && q_head.op == iobm_pkg::OP_FINISH, o_out.valid)
    `IOBM_ASSERT_IMP(a_pop_not_empty, i_clk, i_rst_n, q_pop, !q_status.empty)
    `IOBM_ASSERT_IMP(a_found_priority, i_clk, i_rst_n, o_out.valid && o_out.found, o_out.winner_priority != '0)
    `IOBM_ASSERT_IMP(a_none_clean, i_clk, i_rst_n, o_out.valid && !o_out.found, o_out.match_type == iobm_pkg::CLS_NONE && o_out.winner_id == '0)

endmodule

`default_nettype wire

@@ verif/interval_overlap_best_match_checker.sv @@
`timescale 1ns / 1ps
// scoreboard for the interval overlap best match block: watches the config, item and result
// channels, predicts each finish result and compares it field by field
// depends on iobm_pkg and the channel interfaces in iobm_if.sv

module interval_overlap_best_match_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    iobm_cfg_if       i_cfg,
    iobm_in_if        i_in,
    iobm_out_if       i_res,
    output int        o_fail_count,
    output int        o_pending
);

    localparam int NK  = iobm_pkg::N_KINDS;
    localparam int TW  = iobm_pkg::TOTAL_WIDTH;
    localparam int PW  = iobm_pkg::PRI_WIDTH;
    localparam int IDW = iobm_pkg::ID_WIDTH_DEF;

    typedef struct packed {
        logic                      found;
        iobm_pkg::t_class          cls;
        logic [IDW-1:0]            id;
        logic signed [PW-1:0]      pri;
        iobm_pkg::t_total [NK-1:0] tot;
    } t_match_rec;

    logic [1:0]                type_mode;
    iobm_pkg::t_total          q_lo;
    iobm_pkg::t_total          q_hi;
    iobm_pkg::t_total [NK-1:0] run_tot;
    iobm_pkg::t_total [NK-1:0] best_tot;
    iobm_pkg::t_class          best_cls;
    logic signed [PW-1:0]      best_pri;
    logic [IDW-1:0]            best_id;
    logic                      have_win;
    t_match_rec                winner_q[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic int class_rank(input logic [1:0] mode, input iobm_pkg::t_class c);
        if (c == iobm_pkg::CLS_PARTIAL) begin
            return (mode == iobm_pkg::MODE_INCLUDE_ONLY) ? -1 : 1;
        end else if (c == iobm_pkg::CLS_INCLUDE) begin
            return (mode == iobm_pkg::MODE_EQUAL) ? 1 : 2;
        end
        return 0;
    endfunction

    function automatic bit outranks_best(input iobm_pkg::t_class cls,
                                         input logic signed [PW-1:0] pri);
        int a;
        int b;
        a = class_rank(type_mode, cls);
        b = class_rank(type_mode, best_cls);
        if (a != b) return a > b;
        if ((run_tot[iobm_pkg::KIND_EXON] != 0) != (best_tot[iobm_pkg::KIND_EXON] != 0))
            return run_tot[iobm_pkg::KIND_EXON] != 0;
        if (pri != best_pri) return pri > best_pri;
        for (int k = 0; k < NK; k++) begin
            if (run_tot[k] != best_tot[k]) return run_tot[k] > best_tot[k];
        end
        return 1'b0;
    endfunction

    task automatic clear_query();
        run_tot  = '0;
        best_tot = '0;
        best_cls = iobm_pkg::CLS_NONE;
        best_pri = '0;
        best_id  = '0;
        have_win = 1'b0;
    endtask

    task automatic apply_item();
        iobm_pkg::t_total lo;
        iobm_pkg::t_total hi;
        iobm_pkg::t_total ov;
        logic [TW:0]      sum;
        iobm_pkg::t_class cls;
        t_match_rec       rec;
        case (i_in.cmd)
            iobm_pkg::CMD_START: begin
                q_lo = i_in.query_start;
                q_hi = i_in.query_end;
                clear_query();
            end
            iobm_pkg::CMD_SEG: begin
                lo = (i_in.seg_start > q_lo) ? i_in.seg_start : q_lo;
                hi = (i_in.seg_end < q_hi) ? i_in.seg_end : q_hi;
                ov = (hi > lo) ? hi - lo : '0;
                if (i_in.seg_kind < NK) begin
                    sum = {1'b0, run_tot[i_in.seg_kind]} + {1'b0, ov};
                    run_tot[i_in.seg_kind] = sum[TW] ? '1 : sum[TW-1:0];
                end
                if (i_in.last_of_transcript) begin
                    cls = (i_in.tx_start <= q_lo && i_in.tx_end >= q_hi) ?
                          iobm_pkg::CLS_INCLUDE : iobm_pkg::CLS_PARTIAL;
                    if (i_in.tx_priority != 0 && outranks_best(cls, i_in.tx_priority)) begin
                        best_tot = run_tot;
                        best_cls = cls;
                        best_pri = i_in.tx_priority;
                        best_id  = i_in.tx_id;
                        have_win = 1'b1;
                    end
                    run_tot = '0;
                end
            end
            iobm_pkg::CMD_FINISH: begin
                rec.found = have_win;
                rec.cls   = best_cls;
                rec.id    = best_id;
                rec.pri   = best_pri;
                rec.tot   = best_tot;
                winner_q.push_back(rec);
            end
            default: ;
        endcase
    endtask

    task automatic flag_field(input string fname, input logic [31:0] want,
                              input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 'h%0h, got 'h%0h", fname, want, got);
            o_fail_count++;
        end
    endtask

    task automatic check_result();
        t_match_rec want;
        if (winner_q.size() == 0) begin
            $error("result item with no finish item waiting");
            o_fail_count++;
        end else begin
            want = winner_q.pop_front();
            flag_field("found", 32'(want.found), 32'(i_res.found));
            flag_field("match_type", 32'(want.cls), 32'(i_res.match_type));
            flag_field("winner_id", 32'(want.id), 32'(i_res.winner_id));
            flag_field("winner_priority", 32'(want.pri), 32'(i_res.winner_priority));
            flag_field("exon_overlap", want.tot[0], i_res.exon_overlap);
            flag_field("intron_overlap", want.tot[1], i_res.intron_overlap);
            flag_field("cds_overlap", want.tot[2], i_res.cds_overlap);
            flag_field("utr5_overlap", want.tot[3], i_res.utr5_overlap);
            flag_field("utr3_overlap", want.tot[4], i_res.utr3_overlap);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            type_mode = iobm_pkg::MODE_INCLUDE_FIRST;
            q_lo      = '0;
            q_hi      = '0;
            clear_query();
            winner_q.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) type_mode = i_cfg.data;
            if (i_res.valid && i_res.ready) check_result();
            if (i_in.valid && i_in.ready) apply_item();
        end
        o_pending = winner_q.size();
    end

endmodule

@@ verif/interval_overlap_best_match_tb.sv @@
`timescale 1ns / 1ps
// top of the interval overlap best match testbench: clock, reset, item and config stimulus,
// result-side stalls and the verdict; checking is done by interval_overlap_best_match_checker
// depends on iobm_pkg, iobm_if.sv, the block and the checker

module interval_overlap_best_match_tb;

    localparam int IDLE_LIMIT    = 4000;
    localparam int HOLD_CYCLES   = 200;
    localparam int PHASE_ITEMS   = 110;
    localparam int SETTLE_CYCLES = 8;
    localparam int N_PHASES      = 6;

    localparam int IDW = iobm_pkg::ID_WIDTH_DEF;
    localparam int KW  = iobm_pkg::KIND_WIDTH;
    localparam int PW  = iobm_pkg::PRI_WIDTH;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [1:0] MODE_THREE = 2'd3;

    localparam logic [KW-1:0] KIND_INTRON  = KW'(1);
    localparam logic [KW-1:0] KIND_CDS     = KW'(2);
    localparam logic [KW-1:0] KIND_UTR5    = KW'(3);
    localparam logic [KW-1:0] KIND_UTR3    = KW'(4);
    localparam logic [KW-1:0] KIND_UNKNOWN = KW'(6);

    localparam logic [1:0] PHASE_MODES [N_PHASES] = '{
        iobm_pkg::MODE_INCLUDE_ONLY, iobm_pkg::MODE_EQUAL, MODE_THREE,
        iobm_pkg::MODE_INCLUDE_FIRST, iobm_pkg::MODE_EQUAL, iobm_pkg::MODE_INCLUDE_ONLY
    };

    typedef struct packed {
        logic [1:0]           cmd;
        logic [31:0]          query_start;
        logic [31:0]          query_end;
        logic [31:0]          seg_start;
        logic [31:0]          seg_end;
        logic [KW-1:0]        seg_kind;
        logic [31:0]          tx_start;
        logic [31:0]          tx_end;
        logic signed [PW-1:0] tx_priority;
        logic [IDW-1:0]       tx_id;
        logic                 last;
    } t_annot_req;

    logic clk;
    logic rst_n;
    logic hold_req;
    logic gaps_on;
    int   burst_left;
    int   items_sent;
    int   fail_count;
    int   pending;

    iobm_cfg_if cfg_ch();
    iobm_in_if  in_ch();
    iobm_out_if res_ch();

    interval_overlap_best_match dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (res_ch)
    );

    interval_overlap_best_match_checker u_match_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg        (cfg_ch),
        .i_in         (in_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("status: fail");
        $finish;
    end

    // result side: changing stall styles, plus one long hold-off on request
    initial begin
        int hold_cnt;
        int style;
        int style_left;
        int cyc;
        res_ch.ready = 1'b0;
        hold_cnt     = 0;
        style        = 0;
        style_left   = 0;
        cyc          = 0;
        forever begin
            @(negedge clk);
            cyc++;
            if (style_left == 0) begin
                style      = $urandom_range(0, 3);
                style_left = $urandom_range(20, 80);
            end
            style_left--;
            if (hold_req && hold_cnt < HOLD_CYCLES) begin
                hold_cnt++;
                res_ch.ready <= 1'b0;
            end else begin
                if (!hold_req) hold_cnt = 0;
                case (style)
                    0:       res_ch.ready <= 1'b1;
                    1:       res_ch.ready <= 1'($urandom_range(0, 1));
                    2:       res_ch.ready <= (cyc % 4 == 0);
                    default: res_ch.ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    function automatic t_annot_req noise_req();
        t_annot_req r;
        r.cmd         = 2'($urandom_range(0, 3));
        r.query_start = $urandom;
        r.query_end   = $urandom;
        r.seg_start   = $urandom;
        r.seg_end     = $urandom;
        r.seg_kind    = KW'($urandom_range(0, 7));
        r.tx_start    = $urandom;
        r.tx_end      = $urandom;
        r.tx_priority = PW'($urandom);
        r.tx_id       = IDW'($urandom);
        r.last        = 1'($urandom_range(0, 1));
        return r;
    endfunction

    function automatic t_annot_req unused_req();
        t_annot_req r;
        r     = noise_req();
        r.cmd = CMD_UNUSED;
        return r;
    endfunction

    function automatic t_annot_req start_req(input logic [31:0] qs, input logic [31:0] qe);
        t_annot_req r;
        r             = noise_req();
        r.cmd         = iobm_pkg::CMD_START;
        r.query_start = qs;
        r.query_end   = qe;
        return r;
    endfunction

    function automatic t_annot_req seg_req(input logic [31:0] ss, input logic [31:0] se,
                                           input logic [KW-1:0] kind,
                                           input logic [31:0] ts, input logic [31:0] te,
                                           input int pri, input logic [IDW-1:0] id,
                                           input logic last);
        t_annot_req r;
        r             = noise_req();
        r.cmd         = iobm_pkg::CMD_SEG;
        r.seg_start   = ss;
        r.seg_end     = se;
        r.seg_kind    = kind;
        r.tx_start    = ts;
        r.tx_end      = te;
        r.tx_priority = pri[15:0];
        r.tx_id       = id;
        r.last        = last;
        return r;
    endfunction

    function automatic t_annot_req finish_req();
        t_annot_req r;
        r     = noise_req();
        r.cmd = iobm_pkg::CMD_FINISH;
        return r;
    endfunction

    task automatic drive_req(input t_annot_req r);
        in_ch.valid              <= 1'b1;
        in_ch.cmd                <= r.cmd;
        in_ch.query_start        <= r.query_start;
        in_ch.query_end          <= r.query_end;
        in_ch.seg_start          <= r.seg_start;
        in_ch.seg_end            <= r.seg_end;
        in_ch.seg_kind           <= r.seg_kind;
        in_ch.tx_start           <= r.tx_start;
        in_ch.tx_end             <= r.tx_end;
        in_ch.tx_priority        <= r.tx_priority;
        in_ch.tx_id              <= r.tx_id;
        in_ch.last_of_transcript <= r.last;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic offer(input t_annot_req r);
        int gap;
        if (burst_left == 0) begin
            gap = gaps_on ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        drive_req(r);
        items_sent++;
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        burst_left = 0;
    endtask

    task automatic write_mode(input logic [1:0] mode);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= mode;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // results pile up behind a long hold-off until the input side stalls
    task automatic pressure_burst();
        hold_req = 1'b1;
        gaps_on  = 1'b0;
        offer(start_req(32'd500, 32'd900));
        offer(seg_req(32'd450, 32'd700, iobm_pkg::KIND_EXON, 32'd400, 32'd1000, 3,
                      IDW'(24'h00_0abc), 1'b0));
        offer(seg_req(32'd700, 32'd950, KIND_INTRON, 32'd400, 32'd1000, 3,
                      IDW'(24'h00_0abc), 1'b1));
        repeat (8) offer(finish_req());
        hold_req = 1'b0;
        gaps_on  = 1'b1;
    endtask

    task automatic run_query();
        logic [31:0]    qs;
        logic [31:0]    qe;
        logic [31:0]    ts;
        logic [31:0]    te;
        logic [31:0]    ss;
        logic [31:0]    se;
        logic [KW-1:0]  kind;
        logic [IDW-1:0] id;
        int             ncand;
        int             nseg;
        int             p;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 4)) offer(noise_req());
        end else begin
            case ($urandom_range(0, 7))
                0:       qs = $urandom_range(0, 50);
                1:       qs = 32'hffff_fe00 + $urandom_range(0, 511);
                2:       qs = $urandom;
                default: qs = $urandom_range(1000, 32'h00ff_ffff);
            endcase
            qe = qs + $urandom_range(0, 300);
            if ($urandom_range(0, 15) == 0) qe = $urandom;
            offer(start_req(qs, qe));
            ncand = $urandom_range(0, 4);
            for (int c = 0; c < ncand; c++) begin
                nseg = $urandom_range(1, 4);
                ts   = qs + $urandom_range(0, 100) - 50;
                te   = qe + $urandom_range(0, 100) - 50;
                case ($urandom_range(0, 9))
                    0:       p = 0;
                    1:       p = $urandom;
                    default: p = $urandom_range(0, 6) - 3;
                endcase
                id = IDW'($urandom);
                for (int s = 0; s < nseg; s++) begin
                    kind = KW'(($urandom_range(0, 15) == 0) ? $urandom_range(5, 7)
                                                            : $urandom_range(0, 4));
                    ss = qs + $urandom_range(0, 400) - 100;
                    se = ss + $urandom_range(0, 200);
                    if ($urandom_range(0, 9) == 0) se = ss - $urandom_range(0, 20);
                    if (s == nseg - 1) begin
                        offer(seg_req(ss, se, kind, ts, te, p, id, 1'b1));
                    end else begin
                        offer(seg_req(ss, se, kind, $urandom, $urandom, $urandom,
                                      IDW'($urandom), 1'b0));
                    end
                end
            end
            offer(finish_req());
            if ($urandom_range(0, 5) == 0) offer(finish_req());
        end
    endtask

    initial begin
        int start_count;
        rst_n                    = 1'b0;
        hold_req                 = 1'b0;
        gaps_on                  = 1'b1;
        burst_left               = 0;
        items_sent               = 0;
        in_ch.valid              = 1'b0;
        in_ch.cmd                = iobm_pkg::CMD_START;
        in_ch.query_start        = '0;
        in_ch.query_end          = '0;
        in_ch.seg_start          = '0;
        in_ch.seg_end            = '0;
        in_ch.seg_kind           = iobm_pkg::KIND_EXON;
        in_ch.tx_start           = '0;
        in_ch.tx_end             = '0;
        in_ch.tx_priority        = '0;
        in_ch.tx_id              = '0;
        in_ch.last_of_transcript = 1'b0;
        cfg_ch.valid             = 1'b0;
        cfg_ch.data              = iobm_pkg::MODE_INCLUDE_FIRST;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part, reset mode
        offer(finish_req());
        offer(start_req(32'd100, 32'd200));
        for (int k = 0; k < 8; k++) begin
            offer(seg_req(32'd50 + 10 * k, 32'd150 + 10 * k, KW'(k), 32'd0, 32'd1000, 1,
                          IDW'(1), 1'b0));
        end
        // unknown kind still closes the candidate
        offer(seg_req(32'd120, 32'd180, KIND_UNKNOWN, 32'd0, 32'd1000, 5, IDW'(24'hff_ffff),
                      1'b1));
        // reversed span, zero priority
        offer(seg_req(32'd180, 32'd120, iobm_pkg::KIND_EXON, 32'd150, 32'd1000, 0, IDW'(2),
                      1'b1));
        // no overlap, partial loses to include
        offer(seg_req(32'd300, 32'd400, iobm_pkg::KIND_EXON, 32'd150, 32'd1000, 9, IDW'(3),
                      1'b1));
        offer(unused_req());
        offer(finish_req());
        offer(start_req(32'd0, 32'hffff_ffff));
        offer(seg_req(32'd0, 32'hffff_ffff, iobm_pkg::KIND_EXON, 32'd0, 32'hffff_ffff, 1,
                      IDW'(4), 1'b0));
        offer(seg_req(32'd0, 32'hffff_ffff, iobm_pkg::KIND_EXON, 32'd0, 32'hffff_ffff, 1,
                      IDW'(4), 1'b0));
        offer(seg_req(32'd0, 32'hffff_ffff, KIND_UTR3, 32'd0, 32'hffff_ffff, 1, IDW'(4),
                      1'b0));
        offer(seg_req(32'd5, 32'd9, KIND_UTR5, 32'd0, 32'hffff_ffff, -32768, IDW'(0), 1'b1));
        offer(seg_req(32'd10, 32'd20, KIND_CDS, 32'd5, 32'hffff_ffff, 32767,
                      IDW'(24'h80_0000), 1'b1));
        offer(finish_req());
        offer(finish_req());
        // start drops an open candidate
        offer(seg_req(32'd1, 32'd2, iobm_pkg::KIND_EXON, 32'd0, 32'd10, 7, IDW'(5), 1'b0));
        offer(start_req(32'd1, 32'd2));
        offer(finish_req());

        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain_results();
            write_mode(PHASE_MODES[ph]);
            gaps_on = (ph != 3);
            if (ph == 0) pressure_burst();
            start_count = items_sent;
            while (items_sent - start_count < PHASE_ITEMS) run_query();
        end

        drain_results();
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ interval_overlap_best_match.f @@
+incdir+rtl/core
rtl/core/iobm_pkg.sv
rtl/core/iobm_if.sv
rtl/core/iobm_front.sv
rtl/core/iobm_queue.sv
rtl/core/iobm_back.sv
rtl/core/interval_overlap_best_match.sv
verif/interval_overlap_best_match_checker.sv
verif/interval_overlap_best_match_tb.sv
